/* rtl/core/scc_pkg.sv */
package scc_pkg;

	localparam int unsigned MAX_VERTICES_DEF = 1024;
	localparam int unsigned MAX_EDGES_DEF    = 4096;

	localparam int unsigned REQ_W    = 2;
	localparam int unsigned VTX_W    = 10;
	localparam int unsigned CNT_W    = 11;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR = 2'd0,
		REQ_ADD   = 2'd1,
		REQ_RUN   = 2'd2,
		REQ_QUERY = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_RANGE   = 2'd2,
		ST_NOLABEL = 2'd3
	} status_t;

endpackage

/* rtl/core/scc_ram.sv */
module scc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/strongly_connected_components_core.sv */
// channel  | signals                                   | transfer
// ---------+-------------------------------------------+---------------------------
// request  | req_type, src_vertex, dst_vertex          | start high, busy low
// result   | status, comp_id, comp_count               | done high for one cycle
// config   | cfg_wdata                                 | cfg_we high
//
// Clear sweeps the list heads, one entry per vertex slot; add edge and query
// each read a memory, then act on the data; a refused add or query answers
// straight from idle. A run sweeps MAX_VERTICES entries first, then walks each
// vertex and edge: every step is one read of a registered-read memory and one
// act on the data it returns. After reset the same list-head sweep runs with
// busy high and no result. The receiver cannot stall; results are never held.
module strongly_connected_components_core #(
	parameter int unsigned MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF,
	parameter int unsigned MAX_EDGES    = scc_pkg::MAX_EDGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [scc_pkg::REQ_W-1:0]      req_type,
	input  logic [scc_pkg::VTX_W-1:0]      src_vertex,
	input  logic [scc_pkg::VTX_W-1:0]      dst_vertex,
	input  logic                           cfg_we,
	input  logic [scc_pkg::CNT_W-1:0]      cfg_wdata,
	output logic                           done,
	output logic [scc_pkg::STATUS_W-1:0]   status,
	output logic [scc_pkg::VTX_W-1:0]      comp_id,
	output logic [scc_pkg::CNT_W-1:0]      comp_count
);

	import scc_pkg::*;

	localparam int unsigned VW = $clog2(MAX_VERTICES);
	localparam int unsigned EW = $clog2(MAX_EDGES);
	localparam int unsigned NW = $clog2(MAX_VERTICES + 1);
	localparam int unsigned FW = VW + EW + 1 + NW;

	typedef struct packed {
		logic [VW-1:0] v;
		logic [EW-1:0] e;
		logic          more;
		logic [NW-1:0] low;
	} frame_t;

	typedef enum logic [16:0] {
		S_IDLE    = 17'b00000000000000001,
		S_CLR     = 17'b00000000000000010,
		S_ADD_W   = 17'b00000000000000100,
		S_QRY_W   = 17'b00000000000001000,
		S_INIT    = 17'b00000000000010000,
		S_ROOT    = 17'b00000000000100000,
		S_ROOT_W  = 17'b00000000001000000,
		S_ENTER   = 17'b00000000010000000,
		S_ENTER_W = 17'b00000000100000000,
		S_EDGE    = 17'b00000001000000000,
		S_EDGE_W  = 17'b00000010000000000,
		S_CHK_W   = 17'b00000100000000000,
		S_FIN_W   = 17'b00001000000000000,
		S_POP     = 17'b00010000000000000,
		S_POP_W   = 17'b00100000000000000,
		S_RET     = 17'b01000000000000000,
		S_RET_W   = 17'b10000000000000000
	} state_t;

	state_t         state_q;
	logic [CNT_W-1:0] vc_q;
	logic [EW:0]    eu_q;
	logic [NW-1:0]  sc_q, cc_q, top_q, dep_q, r_q, clow_q;
	logic           lab_q, clr_resp_q;
	logic [VW-1:0]  swp_q, w_q, src_q;
	logic [VTX_W-1:0] dst_q;
	frame_t         cur_q;
	logic           done_q;
	logic [STATUS_W-1:0] status_q;
	logic [VTX_W-1:0] cid_q;

	logic [NW-1:0] n_eff;
	logic [NW-1:0] top_m1, dep_m1, dep_m2;
	logic          src_oor, dst_oor, et_oor, full;

	// memory ports
	logic          hd_we;   logic [VW-1:0] hd_wa, hd_ra; logic [EW:0]   hd_wd, hd_rd;
	logic          tl_we;   logic [VW-1:0] tl_wa, tl_ra; logic [EW-1:0] tl_wd, tl_rd;
	logic          et_we;   logic [EW-1:0] et_wa, et_ra; logic [VTX_W-1:0] et_wd, et_rd;
	logic          el_we;   logic [EW-1:0] el_wa, el_ra; logic [EW-1:0] el_wd, el_rd;
	logic          st_we;   logic [VW-1:0] st_wa, st_ra; logic [NW-1:0] st_wd, st_rd;
	logic          lb_we;   logic [VW-1:0] lb_wa, lb_ra; logic [VW:0]   lb_wd, lb_rd;
	logic          vs_we;   logic [VW-1:0] vs_wa, vs_ra; logic [VW-1:0] vs_wd, vs_rd;
	logic          fr_we;   logic [VW-1:0] fr_wa, fr_ra; logic [FW-1:0] fr_wd, fr_rd;
	frame_t        fr_frame;

	assign n_eff = (32'(vc_q) < 32'(MAX_VERTICES)) ? NW'(vc_q) : NW'(MAX_VERTICES);
	assign top_m1 = top_q - NW'(1);
	assign dep_m1 = dep_q - NW'(1);
	assign dep_m2 = dep_q - NW'(2);
	assign src_oor = 32'(src_vertex) >= 32'(n_eff);
	assign dst_oor = 32'(dst_vertex) >= 32'(n_eff);
	assign et_oor  = 32'(et_rd) >= 32'(n_eff);
	assign full    = 32'(eu_q) == 32'(MAX_EDGES);
	assign fr_frame = frame_t'(fr_rd);

	assign busy       = state_q != S_IDLE;
	assign done       = done_q;
	assign status     = status_q;
	assign comp_id    = cid_q;
	assign comp_count = CNT_W'(cc_q);

	always_comb begin
		hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = VW'(src_vertex);
		tl_we = 1'b0; tl_wa = src_q; tl_wd = eu_q[EW-1:0]; tl_ra = VW'(src_vertex);
		et_we = 1'b0; et_wa = eu_q[EW-1:0]; et_wd = dst_q; et_ra = cur_q.e;
		el_we = 1'b0; el_wa = tl_rd; el_wd = eu_q[EW-1:0]; el_ra = cur_q.e;
		st_we = 1'b0; st_wa = '0; st_wd = '0; st_ra = cur_q.v;
		lb_we = 1'b0; lb_wa = '0; lb_wd = '0; lb_ra = VW'(src_vertex);
		vs_we = 1'b0; vs_wa = top_q[VW-1:0]; vs_wd = w_q; vs_ra = top_m1[VW-1:0];
		fr_we = 1'b0; fr_wa = dep_m1[VW-1:0]; fr_wd = cur_q; fr_ra = dep_m2[VW-1:0];
		unique case (state_q)
			S_CLR: begin
				hd_we = 1'b1;
				hd_wa = swp_q;
			end
			S_ADD_W: begin
				et_we = 1'b1;
				tl_we = 1'b1;
				if (hd_rd[EW]) begin
					el_we = 1'b1;
				end else begin
					hd_we = 1'b1;
					hd_wa = src_q;
					hd_wd = {1'b1, eu_q[EW-1:0]};
				end
			end
			S_INIT: begin
				st_we = 1'b1;
				st_wa = swp_q;
				lb_we = 1'b1;
				lb_wa = swp_q;
			end
			S_ROOT: begin
				lb_ra = r_q[VW-1:0];
			end
			S_ENTER: begin
				st_we = 1'b1;
				st_wa = w_q;
				st_wd = sc_q + NW'(1);
				vs_we = 1'b1;
				fr_we = dep_q != '0;
				hd_ra = w_q;
			end
			S_EDGE: begin
				tl_ra = cur_q.v;
			end
			S_EDGE_W: begin
				lb_ra = VW'(et_rd);
				st_ra = VW'(et_rd);
			end
			S_POP_W: begin
				lb_we = 1'b1;
				lb_wa = vs_rd;
				lb_wd = {1'b1, cc_q[VW-1:0]};
			end
			S_RET: begin
				st_we = 1'b1;
				st_wa = cur_q.v;
				st_wd = cur_q.low;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			vc_q       <= CNT_W'(1);
			eu_q       <= '0;
			sc_q       <= '0;
			cc_q       <= '0;
			top_q      <= '0;
			dep_q      <= '0;
			r_q        <= '0;
			clow_q     <= '0;
			lab_q      <= 1'b0;
			clr_resp_q <= 1'b0;
			swp_q      <= '0;
			w_q        <= '0;
			src_q      <= '0;
			dst_q      <= '0;
			cur_q      <= '0;
			done_q     <= 1'b0;
			status_q   <= ST_OK;
			cid_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				vc_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						src_q <= VW'(src_vertex);
						dst_q <= dst_vertex;
						status_q <= ST_OK;
						cid_q <= '0;
						unique case (req_t'(req_type))
							REQ_CLEAR: begin
								swp_q <= '0;
								eu_q <= '0;
								cc_q <= '0;
								lab_q <= 1'b0;
								clr_resp_q <= 1'b1;
								state_q <= S_CLR;
							end
							REQ_ADD: begin
								if (src_oor || dst_oor) begin
									status_q <= ST_RANGE;
									done_q <= 1'b1;
								end else if (full) begin
									status_q <= ST_FULL;
									done_q <= 1'b1;
								end else begin
									state_q <= S_ADD_W;
								end
							end
							REQ_RUN: begin
								swp_q <= '0;
								state_q <= S_INIT;
							end
							REQ_QUERY: begin
								if (src_oor) begin
									status_q <= ST_RANGE;
									done_q <= 1'b1;
								end else begin
									state_q <= S_QRY_W;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_CLR: begin
					swp_q <= swp_q + VW'(1);
					if (swp_q == VW'(MAX_VERTICES - 1)) begin
						done_q <= clr_resp_q;
						state_q <= S_IDLE;
					end
				end
				S_ADD_W: begin
					eu_q <= eu_q + (EW+1)'(1);
					lab_q <= 1'b0;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_QRY_W: begin
					if (!lab_q || !lb_rd[VW]) begin
						status_q <= ST_NOLABEL;
					end else begin
						cid_q <= VTX_W'(lb_rd[VW-1:0]);
					end
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_INIT: begin
					swp_q <= swp_q + VW'(1);
					if (swp_q == VW'(MAX_VERTICES - 1)) begin
						top_q <= '0;
						dep_q <= '0;
						sc_q <= '0;
						cc_q <= '0;
						r_q <= '0;
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (r_q == n_eff) begin
						lab_q <= 1'b1;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ROOT_W;
					end
				end
				S_ROOT_W: begin
					if (lb_rd[VW]) begin
						r_q <= r_q + NW'(1);
						state_q <= S_ROOT;
					end else begin
						w_q <= r_q[VW-1:0];
						state_q <= S_ENTER;
					end
				end
				S_ENTER: begin
					sc_q <= sc_q + NW'(1);
					top_q <= top_q + NW'(1);
					dep_q <= dep_q + NW'(1);
					state_q <= S_ENTER_W;
				end
				S_ENTER_W: begin
					cur_q.v <= w_q;
					cur_q.low <= sc_q;
					cur_q.more <= hd_rd[EW];
					cur_q.e <= hd_rd[EW-1:0];
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					state_q <= cur_q.more ? S_EDGE_W : S_FIN_W;
				end
				S_EDGE_W: begin
					if (cur_q.e == tl_rd) begin
						cur_q.more <= 1'b0;
					end else begin
						cur_q.e <= el_rd;
					end
					w_q <= VW'(et_rd);
					// targets beyond a lowered vertex count are skipped
					state_q <= et_oor ? S_EDGE : S_CHK_W;
				end
				S_CHK_W: begin
					priority if (lb_rd[VW]) begin
						state_q <= S_EDGE;
					end else if (st_rd != '0) begin
						if (st_rd < cur_q.low) begin
							cur_q.low <= st_rd;
						end
						state_q <= S_EDGE;
					end else begin
						state_q <= S_ENTER;
					end
				end
				S_FIN_W: begin
					state_q <= (cur_q.low == st_rd) ? S_POP : S_RET;
				end
				S_POP: begin
					top_q <= top_m1;
					state_q <= S_POP_W;
				end
				S_POP_W: begin
					if (vs_rd == cur_q.v) begin
						cc_q <= cc_q + NW'(1);
						state_q <= S_RET;
					end else begin
						state_q <= S_POP;
					end
				end
				S_RET: begin
					dep_q <= dep_m1;
					clow_q <= cur_q.low;
					if (dep_m1 != '0) begin
						state_q <= S_RET_W;
					end else begin
						r_q <= r_q + NW'(1);
						state_q <= S_ROOT;
					end
				end
				S_RET_W: begin
					cur_q.v <= fr_frame.v;
					cur_q.e <= fr_frame.e;
					cur_q.more <= fr_frame.more;
					cur_q.low <= (clow_q < fr_frame.low) ? clow_q : fr_frame.low;
					state_q <= S_EDGE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	scc_ram #(.WIDTH(EW + 1), .DEPTH(MAX_VERTICES)) u_head (
		.clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd)
	);
	scc_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_tail (
		.clk(clk), .we(tl_we), .waddr(tl_wa), .wdata(tl_wd), .raddr(tl_ra), .rdata(tl_rd)
	);
	scc_ram #(.WIDTH(VTX_W), .DEPTH(MAX_EDGES)) u_etgt (
		.clk(clk), .we(et_we), .waddr(et_wa), .wdata(et_wd), .raddr(et_ra), .rdata(et_rd)
	);
	scc_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_elink (
		.clk(clk), .we(el_we), .waddr(el_wa), .wdata(el_wd), .raddr(el_ra), .rdata(el_rd)
	);
	scc_ram #(.WIDTH(NW), .DEPTH(MAX_VERTICES)) u_stamp (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd)
	);
	scc_ram #(.WIDTH(VW + 1), .DEPTH(MAX_VERTICES)) u_label (
		.clk(clk), .we(lb_we), .waddr(lb_wa), .wdata(lb_wd), .raddr(lb_ra), .rdata(lb_rd)
	);
	scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vstack (
		.clk(clk), .we(vs_we), .waddr(vs_wa), .wdata(vs_wd), .raddr(vs_ra), .rdata(vs_rd)
	);
	scc_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES)) u_frames (
		.clk(clk), .we(fr_we), .waddr(fr_wa), .wdata(fr_wd), .raddr(fr_ra), .rdata(fr_rd)
	);

endmodule
